// ----- design/inverse_park_clarke_svpwm_macros.svh -----
`ifndef INVERSE_PARK_CLARKE_SVPWM_MACROS_SVH
`define INVERSE_PARK_CLARKE_SVPWM_MACROS_SVH

`ifndef SYNTHESIS
`define IPCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define IPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define IPCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define IPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/ipcs_pkg.sv -----
package ipcs_pkg;

  localparam int unsigned ZW          = 15;
  localparam int unsigned SW          = 17;
  localparam int unsigned SINE_STAGES = 5;
  localparam int unsigned NUM_STAGES  = 12;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [ZW-1:0] Z_ONE      = 15'd16384;

  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [15:0] POLY_B = 16'd42048;
  localparam logic [12:0] POLY_C = 13'd4640;

  localparam logic [15:0] MIN_PULSE_RESET = 16'd1000;

  typedef logic signed [SW-1:0] sine_t;
  typedef logic [SINE_STAGES-1:0] sine_en_t;

endpackage

// ----- design/ipcs_sine.sv -----
module ipcs_sine #(
  parameter int TRIG_BITS = 15
) (
  input  logic              clk_i,
  input  ipcs_pkg::sine_en_t en_i,
  input  logic [15:0]       angle_i,
  output ipcs_pkg::sine_t   sine_o
);
  import ipcs_pkg::*;

  localparam int unsigned SH = 30 - TRIG_BITS;
  localparam logic [32:0] RND = 33'(1) << (29 - TRIG_BITS);
  localparam logic [32:0] LIM = (33'(1) << TRIG_BITS) - 33'(1);

  logic [ZW-1:0] z1_q, z2s_q, z3s_q, z4s_q;
  logic [ZW-1:0] sq2_q, sq3_q;
  logic          n1_q, n2_q, n3_q, n4_q;
  logic [15:0]   inner_q;
  logic [16:0]   mid_q;
  sine_t         sine_q;

  logic [ZW-1:0] z1_d;
  logic [29:0]   zz;
  logic [27:0]   cprod;
  logic [30:0]   mprod;
  logic [31:0]   yprod;
  logic [32:0]   ysum, yshift, ymag;

  always_comb begin
    if (angle_i[14]) begin
      z1_d = Z_ONE - {1'b0, angle_i[13:0]};
    end else begin
      z1_d = {1'b0, angle_i[13:0]};
    end
    zz     = 30'(z1_q) * 30'(z1_q);
    cprod  = 28'(sq2_q) * 28'(POLY_C);
    mprod  = 31'(sq3_q) * 31'(inner_q);
    yprod  = 32'(z4s_q) * 32'(mid_q);
    ysum   = {1'b0, yprod} + RND;
    yshift = ysum >> SH;
    ymag   = (yshift > LIM) ? LIM : yshift;
  end

  // Data registers carry no reset; validity is tracked by the caller.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      z1_q <= z1_d;
      n1_q <= angle_i[15];
    end
    if (en_i[1]) begin
      sq2_q <= zz[28:14];
      z2s_q <= z1_q;
      n2_q  <= n1_q;
    end
    if (en_i[2]) begin
      inner_q <= POLY_B - {2'b00, cprod[27:14]};
      sq3_q   <= sq2_q;
      z3s_q   <= z2s_q;
      n3_q    <= n2_q;
    end
    if (en_i[3]) begin
      mid_q <= POLY_A - mprod[30:14];
      z4s_q <= z3s_q;
      n4_q  <= n3_q;
    end
    if (en_i[4]) begin
      if (n4_q) begin
        sine_q <= -$signed(ymag[SW-1:0]);
      end else begin
        sine_q <= $signed(ymag[SW-1:0]);
      end
    end
  end

  assign sine_o = sine_q;

endmodule

// ----- design/inverse_park_clarke_svpwm.sv -----
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        volt_d, volt_q, rotor_angle
// m_axis    out  m_axis_tvalid/tready        duty_a, duty_b, duty_c
// cfg       in   cfg_wen_i                   min_pulse
//
// Twelve register stages; an item is accepted in every cycle unless every stage
// is full and the output stalls. Five of the stages are the sine polynomial: the
// quadrant fold and one per dependent multiply. Each stage holds when the next
// one is full and stalled, so bubbles close up and input is still taken while
// a result waits. Reset clears the valid bits and sets min_pulse to 1000.
`include "inverse_park_clarke_svpwm_macros.svh"

module inverse_park_clarke_svpwm #(
  parameter int FRAC_BITS = 16,
  parameter int TRIG_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // volt_d [18:0], volt_q [37:19], rotor_angle [53:38], zero [55:54]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // duty_a [17:0], duty_b [35:18], duty_c [53:36], zero [55:54]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_wen_i,
  input  logic [15:0] cfg_wdata_i
);
  import ipcs_pkg::*;

  localparam int unsigned PRW = SW + 19;
  localparam int unsigned UW  = PRW + 1 - TRIG_BITS;
  localparam int unsigned SQW = FRAC_BITS + 2;
  localparam int unsigned TPW = UW + SQW;
  localparam int unsigned TW  = UW + 2;
  localparam int unsigned PW  = UW + 3;
  localparam int unsigned XW  = ((PW > FRAC_BITS + 3) ? PW : FRAC_BITS + 3) + 2;
  localparam int unsigned S5  = SINE_STAGES - 1;

  localparam logic signed [SQW-1:0] SQRT3 = SQW'(64'd1816186 >> (20 - FRAC_BITS));
  localparam logic signed [XW-1:0]  ONE   = XW'(64'd1 << FRAC_BITS);
  localparam logic signed [XW-1:0]  FULL  = XW'(64'd2 << FRAC_BITS);
  localparam logic [17:0]           FULL_OUT = 18'(64'd2 << FRAC_BITS);
  localparam sine_t                 SINE_LIM = SW'((64'd1 << TRIG_BITS) - 64'd1);

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  logic [15:0]           min_pulse_q;

  logic signed [18:0] d_q [SINE_STAGES];
  logic signed [18:0] q_q [SINE_STAGES];

  sine_t sin_s, cos_s;
  logic [15:0] cos_angle;

  logic signed [PRW-1:0] pcd_q, psq_q, pcq_q, psd_q;
  logic signed [UW-1:0]  ua7_q, ub7_q, ua8_q;
  logic signed [TW-1:0]  t8_q;
  logic signed [PW-1:0]  pa9_q, pb9_q, pc9_q;
  logic signed [PW-1:0]  pa10_q, pb10_q, pc10_q, lo10_q, hi10_q;
  logic signed [PW-1:0]  pa11_q, pb11_q, pc11_q, off11_q;
  logic [17:0]           duty_a_q, duty_b_q, duty_c_q;

  logic signed [PRW:0]   diff_a, sum_b;
  logic signed [TPW-1:0] tprod;
  logic signed [PW-1:0]  sb, sc, pb_d, pc_d, lo_d, hi_d;
  logic signed [PW:0]    lohi;
  logic signed [PW-1:0]  off_d;
  logic signed [XW-1:0]  mp, xa, xb, xc;
  logic [17:0]           da_d, db_d, dc_d;

  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign cos_angle     = s_axis_tdata[53:38] + QUARTER_TURN;

  ipcs_sine #(.TRIG_BITS(TRIG_BITS)) u_sin (
    .clk_i  (clk_i),
    .en_i   (en[S5:0]),
    .angle_i(s_axis_tdata[53:38]),
    .sine_o (sin_s)
  );

  ipcs_sine #(.TRIG_BITS(TRIG_BITS)) u_cos (
    .clk_i  (clk_i),
    .en_i   (en[S5:0]),
    .angle_i(cos_angle),
    .sine_o (cos_s)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      min_pulse_q <= MIN_PULSE_RESET;
    end else begin
      if (cfg_wen_i) begin
        min_pulse_q <= cfg_wdata_i;
      end
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    diff_a = (PRW+1)'(pcd_q) - (PRW+1)'(psq_q);
    sum_b  = (PRW+1)'(pcq_q) + (PRW+1)'(psd_q);
    tprod  = TPW'(ub7_q) * TPW'(SQRT3);
    sb     = PW'(t8_q) - PW'(ua8_q);
    sc     = -PW'(ua8_q) - PW'(t8_q);
    pb_d   = (sb + $signed({{(PW-1){1'b0}}, sb[PW-1]})) >>> 1;
    pc_d   = (sc + $signed({{(PW-1){1'b0}}, sc[PW-1]})) >>> 1;
    lo_d   = pa9_q;
    hi_d   = pa9_q;
    if (pb9_q < lo_d) lo_d = pb9_q;
    if (pc9_q < lo_d) lo_d = pc9_q;
    if (pb9_q > hi_d) hi_d = pb9_q;
    if (pc9_q > hi_d) hi_d = pc9_q;
    lohi   = (PW+1)'(lo10_q) + (PW+1)'(hi10_q);
    off_d  = PW'((lohi + $signed({{PW{1'b0}}, lohi[PW]})) >>> 1);
    mp     = $signed({{(XW-16){1'b0}}, min_pulse_q});
    xa     = XW'(pa11_q) - XW'(off11_q) + ONE;
    xb     = XW'(pb11_q) - XW'(off11_q) + ONE;
    xc     = XW'(pc11_q) - XW'(off11_q) + ONE;
    priority if (xa < mp) da_d = '0;
    else if (xa > FULL - mp) da_d = FULL[17:0];
    else da_d = xa[17:0];
    priority if (xb < mp) db_d = '0;
    else if (xb > FULL - mp) db_d = FULL[17:0];
    else db_d = xb[17:0];
    priority if (xc < mp) dc_d = '0;
    else if (xc > FULL - mp) dc_d = FULL[17:0];
    else dc_d = xc[17:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d_q[0] <= $signed(s_axis_tdata[18:0]);
      q_q[0] <= $signed(s_axis_tdata[37:19]);
    end
    for (int k = 1; k < SINE_STAGES; k++) begin
      if (en[k]) begin
        d_q[k] <= d_q[k-1];
        q_q[k] <= q_q[k-1];
      end
    end
    if (en[5]) begin
      pcd_q <= PRW'(cos_s) * PRW'(d_q[S5]);
      psq_q <= PRW'(sin_s) * PRW'(q_q[S5]);
      pcq_q <= PRW'(cos_s) * PRW'(q_q[S5]);
      psd_q <= PRW'(sin_s) * PRW'(d_q[S5]);
    end
    if (en[6]) begin
      ua7_q <= UW'(diff_a >>> TRIG_BITS);
      ub7_q <= UW'(sum_b >>> TRIG_BITS);
    end
    if (en[7]) begin
      ua8_q <= ua7_q;
      t8_q  <= TW'(tprod >>> FRAC_BITS);
    end
    if (en[8]) begin
      pa9_q <= PW'(ua8_q);
      pb9_q <= pb_d;
      pc9_q <= pc_d;
    end
    if (en[9]) begin
      pa10_q <= pa9_q;
      pb10_q <= pb9_q;
      pc10_q <= pc9_q;
      lo10_q <= lo_d;
      hi10_q <= hi_d;
    end
    if (en[10]) begin
      pa11_q  <= pa10_q;
      pb11_q  <= pb10_q;
      pc11_q  <= pc10_q;
      off11_q <= off_d;
    end
    if (en[11]) begin
      duty_a_q <= da_d;
      duty_b_q <= db_d;
      duty_c_q <= dc_d;
    end
  end

  assign m_axis_tvalid = v_q[NUM_STAGES-1];
  assign m_axis_tdata  = {2'b00, duty_c_q, duty_b_q, duty_a_q};

  `IPCS_ASSERT_IMPLY(a_stall_only_when_full, clk_i, rst_ni, !s_axis_tready, &v_q)
  `IPCS_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, v_q[0])
  `IPCS_ASSERT_IMPLY(a_sine_bound, clk_i, rst_ni, v_q[S5], (sin_s <= SINE_LIM) && (sin_s >= -SINE_LIM) && (cos_s <= SINE_LIM) && (cos_s >= -SINE_LIM))
  `IPCS_ASSERT_IMPLY(a_duty_range, clk_i, rst_ni, m_axis_tvalid && (FRAC_BITS <= 16), (duty_a_q <= FULL_OUT) && (duty_b_q <= FULL_OUT) && (duty_c_q <= FULL_OUT))

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import ipcs_pkg::*;

  localparam int FRAC = 16;
  localparam int TRIG = 15;
  localparam longint SQRT3_FRAC = 64'sd1816186 >>> (20 - FRAC);
  localparam longint FULL_SCALE = 64'sd2 << FRAC;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [17:0] a;
    logic [17:0] b;
    logic [17:0] c;
  } duty_set_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // volt_d [18:0], volt_q [37:19], rotor_angle [53:38], zero [55:54]
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // duty_a [17:0], duty_b [35:18], duty_c [53:36], zero [55:54]
  logic [55:0] m_axis_tdata;
  logic        cfg_wen_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  duty_set_t pending_duties[$];
  longint    pulse_margin = longint'(MIN_PULSE_RESET);
  int        errors = 0;
  int        cycles = 0;
  int        burst_left = 0;
  int        rx_left = 0;
  bit        rx_level = 1'b0;
  bit        rx_steady = 1'b0;

  inverse_park_clarke_svpwm #(
    .FRAC_BITS(FRAC),
    .TRIG_BITS(TRIG)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wen_i    (cfg_wen_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint quarter_wave_sine(logic [15:0] ang);
    longint z, z2, inner, mid, y;
    z = longint'(ang[13:0]);
    if (ang[14]) z = 16384 - z;
    z2 = (z * z) >>> 14;
    inner = longint'(POLY_B) - ((z2 * longint'(POLY_C)) >>> 14);
    mid = longint'(POLY_A) - ((z2 * inner) >>> 14);
    y = (z * mid + (64'sd1 <<< (29 - TRIG))) >>> (30 - TRIG);
    if (y > (64'sd1 <<< TRIG) - 1) y = (64'sd1 <<< TRIG) - 1;
    return ang[15] ? -y : y;
  endfunction

  function automatic logic [17:0] shape_duty(longint x, longint offset);
    longint v;
    v = x - offset + (64'sd1 <<< FRAC);
    if (v < pulse_margin) v = 0;
    else if (v > FULL_SCALE - pulse_margin) v = FULL_SCALE;
    return v[17:0];
  endfunction

  function automatic duty_set_t predict_duties(logic signed [18:0] d, logic signed [18:0] q,
                                               logic [15:0] ang);
    longint sn, cs, dv, qv, ua, ub, t, pb, pc, lo, hi, offset;
    duty_set_t r;
    sn = quarter_wave_sine(ang);
    cs = quarter_wave_sine(ang + QUARTER_TURN);
    dv = longint'(d);
    qv = longint'(q);
    ua = (cs * dv - sn * qv) >>> TRIG;
    ub = (cs * qv + sn * dv) >>> TRIG;
    t = (SQRT3_FRAC * ub) >>> FRAC;
    pb = (t - ua) / 2;
    pc = (-ua - t) / 2;
    lo = ua;
    hi = ua;
    if (pb < lo) lo = pb;
    if (pc < lo) lo = pc;
    if (pb > hi) hi = pb;
    if (pc > hi) hi = pc;
    offset = (lo + hi) / 2;
    r.a = shape_duty(ua, offset);
    r.b = shape_duty(pb, offset);
    r.c = shape_duty(pc, offset);
    return r;
  endfunction

  function automatic logic signed [18:0] rand_volt();
    int v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1, 2: v = $urandom_range(0, 262144) - 131072;
      3: v = $urandom_range(0, 4000) - 2000;
      default: v = $urandom_range(0, 1) ? 131072 : -131072;
    endcase
    return v[18:0];
  endfunction

  task automatic report_mismatch(string what, logic [17:0] got, logic [17:0] want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_item(logic signed [18:0] d, logic signed [18:0] q, logic [15:0] ang);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, ang, q, d};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_duties.push_back(predict_duties(d, q, ang));
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      pace();
      send_item(rand_volt(), rand_volt(), 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_min_pulse(logic [15:0] value);
    drain();
    @(negedge clk_i);
    cfg_wen_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_wen_i <= 1'b0;
    pulse_margin = longint'(value);
  endtask

  task automatic test_directed();
    rx_steady = 1'b1;
    send_item(19'sd0, 19'sd0, 16'd0);
    send_item(19'sd131072, 19'sd0, 16'd0);
    send_item(19'sd131072, 19'sd0, 16'd16384);
    send_item(19'sd131072, 19'sd0, 16'd32768);
    send_item(19'sd131072, 19'sd0, 16'd49152);
    send_item(-19'sd131072, 19'sd0, 16'd8192);
    send_item(19'sd0, 19'sd131072, 16'd65535);
    send_item(19'sd0, -19'sd131072, 16'd24576);
    send_item(19'sd65536, 19'sd0, 16'd16383);
    send_item(19'sd65536, 19'sd0, 16'd16385);
    send_item(19'sd262143, 19'sd262143, 16'd4096);
    send_item(19'sh40000, 19'sh40000, 16'd40960);
    send_item(19'sh40000, 19'sd262143, 16'd57344);
    send_item(19'sd100, -19'sd100, 16'd1234);
    send_item(-19'sd1, 19'sd1, 16'd32767);
    send_item(19'sd0, 19'sd65536, 16'd10923);
    send_item(19'sd70000, -19'sd70000, 16'd21845);
    send_item(19'sd1, 19'sd0, 16'd0);
    rx_steady = 1'b0;
    send_item(-19'sd131072, 19'sd131072, 16'd60000);
    send_item(19'sd131072, 19'sd131072, 16'd3000);
    drain();
  endtask

  task automatic test_margin_settings();
    logic [15:0] settings[6];
    settings = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'd65000, 16'd0};
    settings[5] = 16'($urandom_range(0, 65535));
    foreach (settings[i]) begin
      write_min_pulse(settings[i]);
      rx_steady = (i == 0);
      send_random(40);
    end
    rx_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_min_pulse(phase == 0 ? MIN_PULSE_RESET : 16'($urandom_range(0, 5000)));
      send_random(115);
    end
    drain();
  endtask

  always @(negedge clk_i) begin
    if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_level = ($urandom_range(0, 2) != 0);
        rx_left = $urandom_range(1, rx_level ? 16 : 10);
      end
      rx_left--;
      m_axis_tready <= rx_level;
    end
  end

  always @(posedge clk_i) begin : check_results
    duty_set_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_duties.size() == 0) begin
        report_mismatch("unexpected result, duty_a", m_axis_tdata[17:0], '0);
      end else begin
        want = pending_duties.pop_front();
        if (m_axis_tdata[17:0] !== want.a) report_mismatch("duty_a", m_axis_tdata[17:0], want.a);
        if (m_axis_tdata[35:18] !== want.b) report_mismatch("duty_b", m_axis_tdata[35:18], want.b);
        if (m_axis_tdata[53:36] !== want.c) report_mismatch("duty_c", m_axis_tdata[53:36], want.c);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_margin_settings();
    test_random_traffic();
    if (pending_duties.size() != 0) begin
      report_mismatch("results never arrived, count", 18'(pending_duties.size()), 18'd0);
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/ipcs_pkg.sv
design/ipcs_sine.sv
design/inverse_park_clarke_svpwm.sv
sim/tb.sv
